### hdl/irpdt_pkg.sv
package irpdt_pkg;

   localparam int CmdLengthWidth = 5;
   localparam int CmdBitsWidth   = 16;
   localparam int CsrDataWidth   = 16;
   localparam int CsrIndexWidth  = 3;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [CsrIndexWidth-1:0] REG_ADDRESS_PATTERN    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_HEADER_MARK_TICKS  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_HEADER_SPACE_TICKS = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_BIT_MARK_TICKS     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_ONE_SPACE_TICKS    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_ZERO_SPACE_TICKS   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_STOP_MARK_TICKS    = 3'd6;

   localparam logic [CsrDataWidth-1:0] RST_ADDRESS_PATTERN    = 16'd57120;
   localparam logic [CsrDataWidth-1:0] RST_HEADER_MARK_TICKS  = 16'd9000;
   localparam logic [CsrDataWidth-1:0] RST_HEADER_SPACE_TICKS = 16'd4400;
   localparam logic [CsrDataWidth-1:0] RST_BIT_MARK_TICKS     = 16'd600;
   localparam logic [CsrDataWidth-1:0] RST_ONE_SPACE_TICKS    = 16'd500;
   localparam logic [CsrDataWidth-1:0] RST_ZERO_SPACE_TICKS   = 16'd1600;
   localparam logic [CsrDataWidth-1:0] RST_STOP_MARK_TICKS    = 16'd600;

   typedef struct packed {
      logic                      cmd;
      logic [CmdBitsWidth-1:0]   command_bits;
      logic [CmdLengthWidth-1:0] command_length;
   } req_type;

   typedef struct packed {
      logic carrier_on;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [CsrDataWidth-1:0] address_pattern;
      logic [CsrDataWidth-1:0] header_mark_ticks;
      logic [CsrDataWidth-1:0] header_space_ticks;
      logic [CsrDataWidth-1:0] bit_mark_ticks;
      logic [CsrDataWidth-1:0] one_space_ticks;
      logic [CsrDataWidth-1:0] zero_space_ticks;
      logic [CsrDataWidth-1:0] stop_mark_ticks;
   } cfg_type;

   typedef enum logic [5:0] {
      PH_IDLE      = 6'b000001,
      PH_HDR_MARK  = 6'b000010,
      PH_HDR_SPACE = 6'b000100,
      PH_BIT_MARK  = 6'b001000,
      PH_BIT_SPACE = 6'b010000,
      PH_STOP_MARK = 6'b100000
   } phase_type;

   function automatic logic is_mark(phase_type ph);
      return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
   endfunction

endpackage

### hdl/irpdt_csr.sv
module irpdt_csr
   import irpdt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ADDRESS_PATTERN:    cfg_in.address_pattern    = csr_wdata;
            REG_HEADER_MARK_TICKS:  cfg_in.header_mark_ticks  = csr_wdata;
            REG_HEADER_SPACE_TICKS: cfg_in.header_space_ticks = csr_wdata;
            REG_BIT_MARK_TICKS:     cfg_in.bit_mark_ticks     = csr_wdata;
            REG_ONE_SPACE_TICKS:    cfg_in.one_space_ticks    = csr_wdata;
            REG_ZERO_SPACE_TICKS:   cfg_in.zero_space_ticks   = csr_wdata;
            REG_STOP_MARK_TICKS:    cfg_in.stop_mark_ticks    = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_pattern    <= RST_ADDRESS_PATTERN;
         cfg_ff.header_mark_ticks  <= RST_HEADER_MARK_TICKS;
         cfg_ff.header_space_ticks <= RST_HEADER_SPACE_TICKS;
         cfg_ff.bit_mark_ticks     <= RST_BIT_MARK_TICKS;
         cfg_ff.one_space_ticks    <= RST_ONE_SPACE_TICKS;
         cfg_ff.zero_space_ticks   <= RST_ZERO_SPACE_TICKS;
         cfg_ff.stop_mark_ticks    <= RST_STOP_MARK_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/irpdt_load.sv
module irpdt_load
   import irpdt_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 16,
   parameter int COMMAND_WIDTH = 16,
   localparam int SrWidth   = ADDRESS_WIDTH + COMMAND_WIDTH,
   localparam int LeftWidth = $clog2(SrWidth + 1),
   localparam int ClenWidth = $clog2(COMMAND_WIDTH + 1)
)
(
   input  logic [CsrDataWidth-1:0]   address_pattern,
   input  logic [CmdBitsWidth-1:0]   command_bits,
   input  logic [CmdLengthWidth-1:0] command_length,
   output logic [SrWidth-1:0]        shift_bits,
   output logic [LeftWidth-1:0]      bit_count
);

   logic [ClenWidth-1:0]                  clen;
   logic [ClenWidth-1:0]                  pad;
   logic [ADDRESS_WIDTH+CsrDataWidth-1:0] addr_wide;
   logic [COMMAND_WIDTH+CmdBitsWidth-1:0] cmd_wide;
   logic [COMMAND_WIDTH-1:0]              cmd_ext;
   logic [COMMAND_WIDTH-1:0]              cmd_mask;
   logic [COMMAND_WIDTH-1:0]              cmd_field;

   always_comb begin
      if (int'(command_length) > COMMAND_WIDTH) begin
         clen = ClenWidth'(COMMAND_WIDTH);
      end else begin
         clen = ClenWidth'(command_length);
      end
      pad       = ClenWidth'(COMMAND_WIDTH) - clen;
      addr_wide = {{ADDRESS_WIDTH{1'b0}}, address_pattern};
      cmd_wide  = {{COMMAND_WIDTH{1'b0}}, command_bits};
      cmd_ext   = cmd_wide[COMMAND_WIDTH-1:0];
      cmd_mask  = ~({COMMAND_WIDTH{1'b1}} << clen);
      cmd_field = (cmd_ext & cmd_mask) << pad;
      shift_bits = {addr_wide[ADDRESS_WIDTH-1:0], cmd_field};
      bit_count  = LeftWidth'(ADDRESS_WIDTH) + LeftWidth'(clen);
   end

endmodule

### hdl/irpdt_seq.sv
module irpdt_seq
   import irpdt_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 16,
   parameter int COMMAND_WIDTH = 16,
   localparam int SrWidth   = ADDRESS_WIDTH + COMMAND_WIDTH,
   localparam int LeftWidth = $clog2(SrWidth + 1)
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type               phase_ff, phase_in;
   logic [CsrDataWidth-1:0] cnt_ff, cnt_in;
   logic [LeftWidth-1:0]    left_ff, left_in;
   logic [SrWidth-1:0]      sr_ff, sr_in;
   logic                    cur_bit_ff, cur_bit_in;

   logic [SrWidth-1:0]      load_bits;
   logic [LeftWidth-1:0]    load_count;

   irpdt_load #(
      .ADDRESS_WIDTH (ADDRESS_WIDTH),
      .COMMAND_WIDTH (COMMAND_WIDTH)
   ) u_load (
      .address_pattern (cfg.address_pattern),
      .command_bits    (item.command_bits),
      .command_length  (item.command_length),
      .shift_bits      (load_bits),
      .bit_count       (load_count)
   );

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      left_in    = left_ff;
      sr_in      = sr_ff;
      cur_bit_in = cur_bit_ff;
      rsp        = '0;
      if (fire) begin
         if (item.cmd == CMD_START) begin
            if (phase_ff == PH_IDLE) begin
               sr_in      = load_bits;
               left_in    = load_count;
               cur_bit_in = 1'b0;
               phase_in   = PH_HDR_MARK;
               cnt_in     = cfg.header_mark_ticks;
            end
            rsp.carrier_on = is_mark(phase_in);
         end else if (phase_ff != PH_IDLE) begin
            rsp.carrier_on = is_mark(phase_ff);
            if (cnt_ff > CsrDataWidth'(1)) begin
               cnt_in = cnt_ff - CsrDataWidth'(1);
            end else begin
               case (phase_ff)
                  PH_HDR_MARK: begin
                     phase_in = PH_HDR_SPACE;
                     cnt_in   = cfg.header_space_ticks;
                  end
                  PH_HDR_SPACE, PH_BIT_SPACE: begin
                     if (left_ff != '0) begin
                        cur_bit_in = sr_ff[SrWidth-1];
                        sr_in      = sr_ff << 1;
                        left_in    = left_ff - LeftWidth'(1);
                        phase_in   = PH_BIT_MARK;
                        cnt_in     = cfg.bit_mark_ticks;
                     end else begin
                        phase_in = PH_STOP_MARK;
                        cnt_in   = cfg.stop_mark_ticks;
                     end
                  end
                  PH_BIT_MARK: begin
                     phase_in = PH_BIT_SPACE;
                     cnt_in   = cur_bit_ff ? cfg.one_space_ticks : cfg.zero_space_ticks;
                  end
                  default: begin
                     phase_in       = PH_IDLE;
                     cnt_in         = '0;
                     left_in        = '0;
                     cur_bit_in     = 1'b0;
                     rsp.frame_done = 1'b1;
                  end
               endcase
            end
         end
         rsp.busy_res = (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cnt_ff     <= '0;
         left_ff    <= '0;
         sr_ff      <= '0;
         cur_bit_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         left_ff    <= left_in;
         sr_ff      <= sr_in;
         cur_bit_ff <= cur_bit_in;
      end
   end

endmodule

### hdl/ir_pulse_distance_frame_transmitter.sv
// Sends one pulse-distance infrared frame, paced by tick items that each stand for one
// microsecond, and answers every item with one result: the carrier level, the busy flag and
// the frame-done pulse. The block takes one item per clock cycle unless a waiting result
// holds it; each item passes an input register, the frame sequencer and a result register,
// from which its result is offered. A result that waits on the output holds the sequencer,
// and the input then stops taking items once the input register is full.
// Segment lengths are read from the timing registers when each segment begins.
module ir_pulse_distance_frame_transmitter
   import irpdt_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 16,
   parameter int COMMAND_WIDTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   req_type in_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_ff;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   rsp_type seq_rsp;
   cfg_type cfg;

   irpdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpdt_seq #(
      .ADDRESS_WIDTH (ADDRESS_WIDTH),
      .COMMAND_WIDTH (COMMAND_WIDTH)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_ff),
      .cfg   (cfg),
      .rsp   (seq_rsp)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         out_ff <= seq_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/irpdt_checker.sv
module irpdt_checker
   import irpdt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> !rsp_data.busy_res && rsp_data.carrier_on)
      else $error("frame end not reported as the end of a stop mark");

   a_carrier_needs_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.carrier_on && !rsp_data.frame_done |-> rsp_data.busy_res)
      else $error("carrier on outside a frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind ir_pulse_distance_frame_transmitter irpdt_checker u_irpdt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
